// ===== hw/rtl/strg_pkg.sv =====
// ----------------------------------------------------------------------------
// strg_pkg
// Shared types and constants for the subscriber table rate guard.
// ----------------------------------------------------------------------------
`default_nettype none

package strg_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    localparam logic [15:0] MIN_PORT  = 16'd1024;
    localparam logic [39:0] WINDOW_MS = 40'd1000;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_TOUCH = 2'd1;
    localparam logic [1:0] REQ_EVICT = 2'd2;
    localparam logic [1:0] REQ_SEND  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_LOWPORT = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_ALLOW   = 3'd4;
    localparam logic [2:0] ST_DROP    = 3'd5;
    localparam logic [2:0] ST_NOSUB   = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    localparam logic [1:0] CFG_OPEN = 2'd0;
    localparam logic [1:0] CFG_TTL  = 2'd1;
    localparam logic [1:0] CFG_RATE = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [39:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic        report_valid;
        logic [15:0] dropped_reported;
        logic        last;
    } t_rsp;

    // classified command passed from front to back
    typedef struct packed {
        t_req        req;
        logic        reject;
        logic [2:0]  rej_status;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hw/rtl/strg_front.sv =====
// ----------------------------------------------------------------------------
// strg_front
// Input queue stage and request classification (open / port checks).
// ----------------------------------------------------------------------------
`default_nettype none

module strg_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  strg_pkg::t_req    i_req,
    input  wire               push,
    output logic              full,
    input  wire               i_plane_open,
    output strg_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  wire               i_cmd_take
);
    import strg_pkg::*;

    // two-entry queue between front and back
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    t_cmd       cls;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        cls            = '0;
        cls.req        = i_req;
        cls.reject     = 1'b0;
        cls.rej_status = ST_OK;
        if (i_req.req_type == REQ_ADD) begin
            if (!i_plane_open) begin
                cls.reject     = 1'b1;
                cls.rej_status = ST_CLOSED;
            end else if (i_req.peer_port < MIN_PORT) begin
                cls.reject     = 1'b1;
                cls.rej_status = ST_LOWPORT;
            end
        end
    end

    assign full        = (r_cnt == 2'd2);
    assign do_push     = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign do_pop      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (do_push) r_wr <= ~r_wr;
            if (do_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wr] <= cls;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/strg_back.sv =====
// ----------------------------------------------------------------------------
// strg_back
// Slot table and sequencer: walks slots one per cycle, stalling on a busy output.
// ----------------------------------------------------------------------------
`default_nettype none

module strg_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  strg_pkg::t_cmd    i_cmd,
    input  wire               i_cmd_valid,
    output logic              o_cmd_take,
    input  wire [31:0]        i_ttl,
    input  wire [15:0]        i_rate,
    output strg_pkg::t_rsp    o_rsp,
    output logic              o_empty,
    input  wire               i_pop
);
    import strg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [SLOTS-1:0] r_active;
    logic [31:0]      r_ip   [SLOTS];
    logic [15:0]      r_port [SLOTS];
    logic [39:0]      r_hb   [SLOTS];
    logic [39:0]      r_win  [SLOTS];
    logic [15:0]      r_sends[SLOTS];
    logic [15:0]      r_drops[SLOTS];

    logic [1:0]       r_st;
    t_cmd             r_cmd;
    logic [CNT_W-1:0] r_idx;
    logic             r_found;
    logic [SLOT_W-1:0] r_first;
    logic             r_have_free;
    logic [SLOT_W-1:0] r_free;

    // one-entry output register
    t_rsp             r_out;
    logic             r_out_v;

    logic [SLOT_W-1:0] idx;
    logic              act;
    logic              ip_eq;
    logic              port_eq;
    logic [39:0]       hb_age;
    logic [39:0]       win_age;
    logic              roll;
    logic [15:0]       sends_c;
    logic [15:0]       drops_c;
    logic              out_free;
    logic              out_load;
    logic              at_end;
    logic [2:0]        slot3;

    assign idx     = r_idx[SLOT_W-1:0];
    assign act     = r_active[idx];
    assign ip_eq   = (r_ip[idx] == r_cmd.req.peer_ip);
    assign port_eq = (r_port[idx] == r_cmd.req.peer_port);
    assign hb_age  = (r_cmd.req.now_ms >= r_hb[idx]) ? r_cmd.req.now_ms - r_hb[idx] : '0;
    assign win_age = (r_cmd.req.now_ms >= r_win[idx]) ? r_cmd.req.now_ms - r_win[idx] : '0;
    assign roll    = (win_age >= WINDOW_MS);
    assign sends_c = roll ? 16'd0 : r_sends[idx];
    assign drops_c = roll ? 16'd0 : r_drops[idx];
    assign out_free = !r_out_v || i_pop;
    assign at_end   = (r_idx == CNT_W'(SLOTS - 1));
    assign slot3    = 3'(idx);

    // a result is loaded by a send on an active slot or by the single-result tail
    assign out_load = out_free && ((r_st == S_FIN) ||
                      (r_st == S_SCAN && r_cmd.req.req_type == REQ_SEND && act));

    assign o_empty    = !r_out_v;
    assign o_rsp      = r_out;
    assign o_cmd_take = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_active <= '0;
            r_out_v  <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (out_load) r_out_v <= 1'b1;
            else if (i_pop) r_out_v <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd       <= i_cmd;
                        r_idx       <= '0;
                        r_found     <= 1'b0;
                        r_first     <= '0;
                        r_have_free <= 1'b0;
                        r_free      <= '0;
                        r_st        <= i_cmd.reject ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    case (r_cmd.req.req_type)
                        REQ_ADD: begin
                            if (act && ip_eq && port_eq) begin
                                r_hb[idx] <= r_cmd.req.now_ms;
                                r_found   <= 1'b1;
                                r_first   <= idx;
                                r_st      <= S_FIN;
                            end else begin
                                if (!act && !r_have_free) begin
                                    r_have_free <= 1'b1;
                                    r_free      <= idx;
                                end
                                if (at_end) r_st <= S_FILL;
                                else r_idx <= r_idx + 1'b1;
                            end
                        end
                        REQ_TOUCH: begin
                            if (act && ip_eq) begin
                                r_hb[idx] <= r_cmd.req.now_ms;
                                if (!r_found) begin
                                    r_found <= 1'b1;
                                    r_first <= idx;
                                end
                            end
                            if (at_end) r_st <= S_FIN;
                            else r_idx <= r_idx + 1'b1;
                        end
                        REQ_EVICT: begin
                            if (act && (hb_age > {8'd0, i_ttl})) r_active[idx] <= 1'b0;
                            if (at_end) r_st <= S_FIN;
                            else r_idx <= r_idx + 1'b1;
                        end
                        default: begin
                            // send: one result per active slot
                            if (!act) begin
                                if (at_end) r_st <= S_FIN;
                                else r_idx <= r_idx + 1'b1;
                            end else if (out_free) begin
                                r_out.slot <= slot3;
                                r_out.report_valid <= roll && (r_drops[idx] != 16'd0);
                                r_out.dropped_reported <= roll ? r_drops[idx] : 16'd0;
                                r_out.last <= at_end ||
                                    (r_active >> (idx + 1'b1)) == '0;
                                if (roll) r_win[idx] <= r_cmd.req.now_ms;
                                if (sends_c >= i_rate) begin
                                    r_out.status <= ST_DROP;
                                    r_drops[idx] <= (drops_c != CNT_MAX) ? drops_c + 1'b1
                                                                         : drops_c;
                                    r_sends[idx] <= sends_c;
                                end else begin
                                    r_out.status <= ST_ALLOW;
                                    r_sends[idx] <= sends_c + 1'b1;
                                    r_drops[idx] <= drops_c;
                                end
                                if (at_end || (r_active >> (idx + 1'b1)) == '0) r_st <= S_IDLE;
                                else r_idx <= r_idx + 1'b1;
                            end
                        end
                    endcase
                end
                S_FILL: begin
                    if (r_have_free) begin
                        r_active[r_free] <= 1'b1;
                        r_ip[r_free]     <= r_cmd.req.peer_ip;
                        r_port[r_free]   <= r_cmd.req.peer_port;
                        r_hb[r_free]     <= r_cmd.req.now_ms;
                        r_win[r_free]    <= r_cmd.req.now_ms;
                        r_sends[r_free]  <= 16'd0;
                        r_drops[r_free]  <= 16'd0;
                        r_found          <= 1'b1;
                        r_first          <= r_free;
                    end
                    r_st <= S_FIN;
                end
                default: begin
                    // single-result tail
                    if (out_free) begin
                        r_out.slot             <= 3'd0;
                        r_out.report_valid     <= 1'b0;
                        r_out.dropped_reported <= 16'd0;
                        r_out.last             <= 1'b1;
                        if (r_cmd.reject) begin
                            r_out.status <= r_cmd.rej_status;
                        end else begin
                            case (r_cmd.req.req_type)
                                REQ_ADD: begin
                                    r_out.status <= r_found ? ST_OK : ST_FULL;
                                    if (r_found) r_out.slot <= 3'(r_first);
                                end
                                REQ_TOUCH: begin
                                    r_out.status <= r_found ? ST_OK : ST_NOSUB;
                                    if (r_found) r_out.slot <= 3'(r_first);
                                end
                                REQ_EVICT: r_out.status <= ST_DONE;
                                default:   r_out.status <= ST_NOSUB;
                            endcase
                        end
                        r_st <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/subscriber_table_rate_guard.sv =====
// A send emits one result per active slot, one per cycle while the output
// register is free; inactive slots are stepped over without a result. The back
// end walks the table one slot per cycle while not stalled on the output and
// takes a new command only when idle, once the last walk is done. Synchronous
// active-low reset clears the slot valid bits, the queues and restores defaults.
// ----------------------------------------------------------------------------
// subscriber_table_rate_guard
// Subscriber slot table with heartbeat expiry and per-slot rate limiting.
// ----------------------------------------------------------------------------
`default_nettype none

module subscriber_table_rate_guard (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  strg_pkg::t_req    i_req,
    input  wire               push,
    output logic              full,
    output strg_pkg::t_rsp    o_rsp,
    output logic              empty,
    input  wire               pop,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [1:0]         i_cfg_index,
    input  wire [31:0]        i_cfg_data
);
    import strg_pkg::*;

    logic        r_open;
    logic [31:0] r_ttl;
    logic [15:0] r_rate;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b1;
            r_ttl  <= 32'd5000;
            r_rate <= 16'd60;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OPEN: r_open <= i_cfg_data[0];
                CFG_TTL:  r_ttl  <= i_cfg_data;
                CFG_RATE: r_rate <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    strg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .push         (push),
        .full         (full),
        .i_plane_open (r_open),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_take   (cmd_take)
    );

    strg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .i_ttl       (r_ttl),
        .i_rate      (r_rate),
        .o_rsp       (o_rsp),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/strg_checker.sv =====
// ----------------------------------------------------------------------------
// strg_checker
// Port-level checks on the rate guard, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module strg_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               full,
    input  wire               empty,
    input  wire               pop,
    input  strg_pkg::t_rsp    o_rsp
);
    import strg_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_rsp)))
        else $error("result changed while waiting");

    // report fields only on send results
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rsp.status != ST_ALLOW && o_rsp.status != ST_DROP)
            |-> (!o_rsp.report_valid && o_rsp.dropped_reported == 16'd0))
        else $error("report on non-send result");

    // non-send results are always final
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_rsp.status != ST_ALLOW && o_rsp.status != ST_DROP)
            |-> o_rsp.last)
        else $error("single result not marked last");

    // out of reset nothing is pending
    a_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("not empty after reset");

endmodule

bind subscriber_table_rate_guard strg_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_rsp   (o_rsp)
);

`default_nettype wire
